@@ rtl/core/rref_pkg.sv @@
// Package for the request/reply envelope filter: result kinds, command codes,
// reply phases, register indexes and the result record type. No dependencies.
package rref_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int ID_BYTES     = 4;

	typedef enum logic [2:0] {
		K_ERR     = 3'd0,
		K_ID      = 3'd1,
		K_DELIM   = 3'd2,
		K_FWD     = 3'd3,
		K_ABANDON = 3'd4,
		K_DELIVER = 3'd5,
		K_DISCARD = 3'd6,
		K_DONE    = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		CMD_SEND   = 2'd0,
		CMD_ARRIVE = 2'd1,
		CMD_TERM   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_DELIM = 2'd1,
		PH_BODY  = 2'd2,
		PH_SKIP  = 2'd3
	} phase_t;

	localparam logic [1:0] REG_CORRELATE = 2'd0;
	localparam logic [1:0] REG_STRICT    = 2'd1;
	localparam logic [1:0] REG_SEED      = 2'd2;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  ch;
		logic        more;
		logic [31:0] id;
	} res_t;

	function automatic res_t mk_res(kind_t k, logic [2:0] c, logic m, logic [31:0] v);
		res_t r;
		r.kind = k;
		r.ch   = c;
		r.more = m;
		r.id   = v;
		return r;
	endfunction

endpackage

@@ rtl/core/request_reply_envelope_filter.sv @@
// Request/reply envelope filter: sequences sends and arrivals, holds up to
// four results per item in a small result buffer. Depends on rref_pkg.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    cmd, frame_more, frame_size, first_word, channel
//   out      out_valid/out_ready  kind, out_channel, out_more, id_value, last
//   cfg      APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// An item is decoded in the cycle it is accepted; its one to four results are
// loaded into the result buffer and leave one per cycle while out_ready is high,
// so an item holds the output until all of its results (1 to 4) have been taken.
// A new item is taken while the last pending result is being taken.
// Reset clears the envelope state and loads the counter from the seed (0).
module request_reply_envelope_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic        frame_more,
	input  logic [15:0] frame_size,
	input  logic [31:0] first_word,
	input  logic [2:0]  channel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [2:0]  out_channel,
	output logic        out_more,
	output logic [31:0] id_value,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rref_pkg::*;

	logic        corr_q, strict_q;
	logic [31:0] seed_q, counter_q;
	logic        await_q, start_q, rcv_q;
	phase_t      phase_q;
	logic [2:0]  rch_q;

	logic        await_d, start_d, rcv_d;
	phase_t      phase_d;
	logic [2:0]  rch_d;
	logic [31:0] counter_d;

	res_t        buf_q [4];
	logic [2:0]  cnt_q;
	res_t        slot [4];
	logic [2:0]  n_res;

	logic in_fire, out_fire, cfg_wr;
	logic ch_ok, s_err, s_start, a_disc, env_ok;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign out_valid = (cnt_q != 3'd0);
	assign in_ready  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	assign kind        = buf_q[0].kind;
	assign out_channel = buf_q[0].ch;
	assign out_more    = buf_q[0].more;
	assign id_value    = buf_q[0].id;
	assign last        = (cnt_q == 3'd1);

	always_comb begin
		unique case (paddr[3:2])
			REG_CORRELATE: prdata = {31'd0, corr_q};
			REG_STRICT:    prdata = {31'd0, strict_q};
			REG_SEED:      prdata = seed_q;
			default:       prdata = 32'd0;
		endcase
	end

	// decode
	assign ch_ok   = (32'(channel) < NUM_CHANNELS);
	assign s_err   = !ch_ok || (await_q && strict_q);
	assign s_start = !s_err && (await_q || start_q);
	assign a_disc  = !await_q || !ch_ok || (rcv_q && (channel != rch_q));
	assign env_ok  = (phase_q == PH_START && corr_q)
		? (frame_more && frame_size == 16'(ID_BYTES) && first_word == counter_q)
		: (frame_more && frame_size == 16'd0);

	// next state
	always_comb begin
		await_d   = await_q;
		start_d   = start_q;
		rcv_d     = rcv_q;
		phase_d   = phase_q;
		rch_d     = rch_q;
		counter_d = counter_q;
		unique case (cmd)
			CMD_SEND: begin
				if (!s_err) begin
					if (s_start) begin
						await_d   = 1'b0;
						start_d   = 1'b0;
						rcv_d     = 1'b1;
						rch_d     = channel;
						counter_d = counter_q + 32'(corr_q);
					end
					if (!frame_more) begin
						await_d = 1'b1;
						start_d = 1'b1;
						phase_d = PH_START;
					end
				end
			end
			CMD_ARRIVE: begin
				if (!a_disc) begin
					unique case (phase_q)
						PH_START, PH_DELIM: begin
							if (env_ok)
								phase_d = (phase_q == PH_START && corr_q) ? PH_DELIM : PH_BODY;
							else
								phase_d = frame_more ? PH_SKIP : PH_START;
						end
						PH_BODY: begin
							if (!frame_more) begin
								await_d = 1'b0;
								start_d = 1'b1;
								phase_d = PH_START;
							end
						end
						PH_SKIP: begin
							if (!frame_more)
								phase_d = PH_START;
						end
						default: phase_d = phase_q;
					endcase
				end
			end
			CMD_TERM: begin
				if (rcv_q && rch_q == channel)
					rcv_d = 1'b0;
			end
			default: rcv_d = rcv_q;
		endcase
	end

	// results
	always_comb begin
		for (int i = 0; i < 4; i++)
			slot[i] = mk_res(K_ERR, 3'd0, 1'b0, 32'd0);
		n_res = 3'd0;
		unique case (cmd)
			CMD_SEND: begin
				if (s_err) begin
					slot[0] = mk_res(K_ERR, channel, 1'b0, 32'd0);
					n_res   = 3'd1;
				end else begin
					if (await_q && rcv_q) begin
						slot[n_res[1:0]] = mk_res(K_ABANDON, rch_q, 1'b0, 32'd0);
						n_res = n_res + 3'd1;
					end
					if (s_start && corr_q) begin
						slot[n_res[1:0]] = mk_res(K_ID, channel, 1'b1, counter_q + 32'd1);
						n_res = n_res + 3'd1;
					end
					if (s_start) begin
						slot[n_res[1:0]] = mk_res(K_DELIM, channel, 1'b1, 32'd0);
						n_res = n_res + 3'd1;
					end
					slot[n_res[1:0]] = mk_res(K_FWD, (!s_start && rcv_q) ? rch_q : channel,
						frame_more, 32'd0);
					n_res = n_res + 3'd1;
				end
			end
			CMD_ARRIVE: begin
				n_res = 3'd1;
				if (a_disc)
					slot[0] = mk_res(K_DISCARD, channel, 1'b0, 32'd0);
				else if (phase_q == PH_BODY)
					slot[0] = mk_res(K_DELIVER, channel, frame_more, 32'd0);
				else if (phase_q == PH_SKIP || !env_ok)
					slot[0] = mk_res(K_DISCARD, channel, 1'b0, 32'd0);
				else
					slot[0] = mk_res(K_DONE, channel, 1'b0, 32'd0);
			end
			CMD_TERM: begin
				slot[0] = mk_res(K_DONE, channel, 1'b0, 32'd0);
				n_res   = 3'd1;
			end
			default: begin
				slot[0] = mk_res(K_ERR, channel, 1'b0, 32'd0);
				n_res   = 3'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_q    <= 1'b0;
			strict_q  <= 1'b1;
			seed_q    <= 32'd0;
			counter_q <= 32'd0;
			await_q   <= 1'b0;
			start_q   <= 1'b1;
			rcv_q     <= 1'b0;
			phase_q   <= PH_START;
			rch_q     <= 3'd0;
			cnt_q     <= 3'd0;
		end else begin
			if (in_fire) begin
				await_q   <= await_d;
				start_q   <= start_d;
				rcv_q     <= rcv_d;
				phase_q   <= phase_d;
				rch_q     <= rch_d;
				counter_q <= counter_d;
				cnt_q     <= n_res;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 3'd1;
			end
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_CORRELATE: corr_q <= pwdata[0];
					REG_STRICT:    strict_q <= pwdata[0];
					REG_SEED: begin
						seed_q    <= pwdata;
						counter_q <= pwdata;
					end
					default: ;
				endcase
			end
		end
	end

	// load or shift the result buffer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < 4; i++)
				buf_q[i] <= slot[i];
		end else if (out_fire) begin
			for (int i = 0; i < 3; i++)
				buf_q[i] <= buf_q[i + 1];
		end
	end

`ifndef ASSERT_OFF
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (cnt_q >= 3'd1 && cnt_q <= 3'd4))
		else $error("accepted item left no result");
	a_strict: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_SEND && await_q && strict_q) |=>
		(kind == K_ERR && cnt_q == 3'd1))
		else $error("strict send while awaiting not refused");
	a_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == K_ID) |-> corr_q)
		else $error("id frame without correlation");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result count overflow");
`endif

endmodule

@@ tb/rref_checker.sv @@
// Checker for the request/reply envelope filter: watches the item, result and
// register ports, predicts each item's results and compares them in order.
// Depends on rref_pkg.
module rref_checker
	import rref_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic        frame_more,
	input  logic [15:0] frame_size,
	input  logic [31:0] first_word,
	input  logic [2:0]  channel,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  kind,
	input  logic [2:0]  out_channel,
	input  logic        out_more,
	input  logic [31:0] id_value,
	input  logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output logic [31:0] req_id
);

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  ch;
		logic        more;
		logic [31:0] id;
		logic        last;
	} action_t;

	action_t    expected_actions[$];
	action_t    got, want;
	logic       corr_en, strict_on;
	logic       awaiting, starting;
	phase_t     phase;
	logic [2:0] reply_ch;
	logic       reply_ch_ok;

	task automatic emit(kind_t k, logic [2:0] c, logic m, logic [31:0] v);
		action_t a;
		a.kind = k;
		a.ch   = c;
		a.more = m;
		a.id   = v;
		a.last = 1'b0;
		expected_actions.push_back(a);
	endtask

	task automatic predict_send(logic [2:0] c, logic m);
		if (c >= NUM_CHANNELS) begin
			emit(K_ERR, c, 1'b0, 32'd0);
			return;
		end
		if (awaiting) begin
			if (strict_on) begin
				emit(K_ERR, c, 1'b0, 32'd0);
				return;
			end
			if (reply_ch_ok)
				emit(K_ABANDON, reply_ch, 1'b0, 32'd0);
			awaiting = 1'b0;
			starting = 1'b1;
		end
		if (starting) begin
			reply_ch_ok = 1'b0;
			if (corr_en) begin
				req_id = req_id + 32'd1;
				emit(K_ID, c, 1'b1, req_id);
			end
			emit(K_DELIM, c, 1'b1, 32'd0);
			reply_ch    = c;
			reply_ch_ok = 1'b1;
			starting    = 1'b0;
		end
		emit(K_FWD, reply_ch_ok ? reply_ch : c, m, 32'd0);
		if (!m) begin
			awaiting = 1'b1;
			starting = 1'b1;
			phase    = PH_START;
		end
	endtask

	task automatic predict_arrival(logic [2:0] c, logic m, logic [15:0] sz, logic [31:0] w);
		logic   good;
		phase_t nxt;
		if (!awaiting || c >= NUM_CHANNELS || (reply_ch_ok && c != reply_ch)) begin
			emit(K_DISCARD, c, 1'b0, 32'd0);
			return;
		end
		if (phase == PH_BODY) begin
			emit(K_DELIVER, c, m, 32'd0);
			if (!m) begin
				awaiting = 1'b0;
				starting = 1'b1;
				phase    = PH_START;
			end
		end else if (phase == PH_SKIP) begin
			emit(K_DISCARD, c, 1'b0, 32'd0);
			if (!m)
				phase = PH_START;
		end else begin
			if (phase == PH_START && corr_en) begin
				good = m && sz == ID_BYTES && w == req_id;
				nxt  = PH_DELIM;
			end else begin
				good = m && sz == 16'd0;
				nxt  = PH_BODY;
			end
			if (good) begin
				phase = nxt;
				emit(K_DONE, c, 1'b0, 32'd0);
			end else begin
				emit(K_DISCARD, c, 1'b0, 32'd0);
				phase = m ? PH_SKIP : PH_START;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_actions.delete();
			corr_en     = 1'b0;
			strict_on   = 1'b1;
			req_id      = 32'd0;
			awaiting    = 1'b0;
			starting    = 1'b1;
			phase       = PH_START;
			reply_ch    = 3'd0;
			reply_ch_ok = 1'b0;
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_CORRELATE: corr_en = pwdata[0];
					REG_STRICT:    strict_on = pwdata[0];
					REG_SEED:      req_id = pwdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.kind = kind_t'(kind);
				got.ch   = out_channel;
				got.more = out_more;
				got.id   = id_value;
				got.last = last;
				if (expected_actions.size() == 0) begin
					$display("%0t: unexpected result kind=%0d ch=%0d more=%0d id=%08h last=%0d",
						$time, kind, out_channel, out_more, id_value, last);
					fail_count++;
				end else begin
					want = expected_actions.pop_front();
					if (got !== want) begin
						$display("%0t: expected kind=%0d ch=%0d more=%0d id=%08h last=%0d",
							$time, want.kind, want.ch, want.more, want.id, want.last);
						$display("%0t:   actual kind=%0d ch=%0d more=%0d id=%08h last=%0d",
							$time, kind, out_channel, out_more, id_value, last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (cmd)
					CMD_SEND:   predict_send(channel, frame_more);
					CMD_ARRIVE: predict_arrival(channel, frame_more, frame_size, first_word);
					CMD_TERM: begin
						if (reply_ch_ok && reply_ch == channel)
							reply_ch_ok = 1'b0;
						emit(K_DONE, channel, 1'b0, 32'd0);
					end
					default: emit(K_ERR, channel, 1'b0, 32'd0);
				endcase
				expected_actions[expected_actions.size() - 1].last = 1'b1;
			end
			pending = expected_actions.size();
		end
	end

endmodule

@@ tb/tb_request_reply_envelope_filter.sv @@
// Testbench top for the request/reply envelope filter: clock, reset, register
// writes and item stimulus with random idling; rref_checker does the checking.
// Depends on rref_pkg, request_reply_envelope_filter and rref_checker.
module tb_request_reply_envelope_filter;
	import rref_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic        frame_more;
	logic [15:0] frame_size;
	logic [31:0] first_word;
	logic [2:0]  channel;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [2:0]  out_channel;
	logic        out_more;
	logic [31:0] id_value;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	logic [31:0] req_id;

	bit quiet;
	bit counting;
	bit corr_now;
	bit strict_now;
	int n_rand;

	request_reply_envelope_filter u_dut (.*);
	rref_checker u_check (.*);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int len;
		bit stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_ready = 1'b1;
			end else begin
				stall = ($urandom_range(0, 2) == 0);
				len = stall ? $urandom_range(1, 14) : $urandom_range(1, 30);
				out_ready = !stall;
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	task automatic put_item(logic [1:0] c, logic m, logic [15:0] sz, logic [31:0] w,
		bit xor_id, logic [2:0] ch);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd        = c;
		frame_more = m;
		frame_size = sz;
		first_word = xor_id ? (req_id ^ w) : w;
		channel    = ch;
		in_valid   = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (counting)
			n_rand++;
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] d);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = d;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_config(bit corr, bit strict, logic [31:0] seed);
		settle();
		reg_write(REG_CORRELATE, {31'd0, corr});
		reg_write(REG_STRICT, {31'd0, strict});
		reg_write(REG_SEED, seed);
		corr_now   = corr;
		strict_now = strict;
	endtask

	task automatic maybe_noise(logic [2:0] rc, bit in_reply);
		logic [2:0] other;
		int pick;
		if ($urandom_range(0, 7) != 0)
			return;
		other = rc + 3'($urandom_range(1, 7));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			put_item(CMD_ARRIVE, 1'($urandom_range(0, 1)), 16'($urandom), $urandom, 1'b0,
				other);
		else if (pick < 6)
			put_item(CMD_TERM, 1'($urandom_range(0, 1)), 16'($urandom), $urandom, 1'b0,
				(!strict_now && pick == 5) ? rc : other);
		else if (pick < 8)
			put_item(CMD_UNUSED, 1'($urandom_range(0, 1)), 16'($urandom), $urandom, 1'b0,
				3'($urandom_range(0, 7)));
		else if (in_reply)
			put_item(CMD_SEND, 1'($urandom_range(0, 1)), 16'($urandom), $urandom, 1'b0,
				3'($urandom_range(0, 7)));
		else
			put_item(CMD_ARRIVE, 1'($urandom_range(0, 1)), 16'($urandom), $urandom, 1'b0,
				other);
	endtask

	task automatic broken_message(logic [2:0] rc);
		int variant;
		int nfill;
		logic bm;
		logic [15:0] sz;
		variant = corr_now ? $urandom_range(0, 5) : $urandom_range(3, 5);
		if (corr_now && variant >= 3)
			put_item(CMD_ARRIVE, 1'b1, 16'(ID_BYTES), 32'd0, 1'b1, rc);
		case (variant)
			0: begin
				sz = 16'($urandom);
				if (sz == ID_BYTES)
					sz = 16'hFFFF;
				bm = 1'b1;
				put_item(CMD_ARRIVE, bm, sz, 32'd0, 1'b1, rc);
			end
			1: begin
				bm = 1'($urandom_range(0, 1));
				put_item(CMD_ARRIVE, bm, 16'(ID_BYTES), $urandom | 32'd1, 1'b1, rc);
			end
			2: begin
				bm = 1'b0;
				put_item(CMD_ARRIVE, bm, 16'(ID_BYTES), 32'd0, 1'b1, rc);
			end
			3: begin
				bm = 1'b1;
				put_item(CMD_ARRIVE, bm, 16'($urandom_range(1, 65535)), $urandom, 1'b0, rc);
			end
			4: begin
				bm = 1'b0;
				put_item(CMD_ARRIVE, bm, 16'd0, $urandom, 1'b0, rc);
			end
			default: begin
				bm = 1'($urandom_range(0, 1));
				put_item(CMD_ARRIVE, bm, 16'($urandom), $urandom, 1'b0, rc);
			end
		endcase
		if (bm) begin
			nfill = $urandom_range(0, 2);
			repeat (nfill) put_item(CMD_ARRIVE, 1'b1, 16'($urandom), $urandom, 1'b0, rc);
			put_item(CMD_ARRIVE, 1'b0, 16'($urandom), $urandom, 1'b0, rc);
		end
	endtask

	task automatic exchange();
		logic [2:0] rc;
		int nreq;
		int nbody;
		int tries;
		rc = 3'($urandom_range(0, 7));
		nreq = $urandom_range(1, 3);
		for (int i = 0; i < nreq; i++) begin
			maybe_noise(rc, 1'b0);
			put_item(CMD_SEND, i != nreq - 1, 16'($urandom), $urandom, 1'b0, rc);
		end
		tries = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (tries) begin
			maybe_noise(rc, 1'b1);
			broken_message(rc);
		end
		if (corr_now) begin
			maybe_noise(rc, 1'b1);
			put_item(CMD_ARRIVE, 1'b1, 16'(ID_BYTES), 32'd0, 1'b1, rc);
		end
		maybe_noise(rc, 1'b1);
		put_item(CMD_ARRIVE, 1'b1, 16'd0, $urandom, 1'b0, rc);
		nbody = $urandom_range(1, 3);
		for (int i = 0; i < nbody; i++) begin
			maybe_noise(rc, 1'b1);
			put_item(CMD_ARRIVE, i != nbody - 1, 16'($urandom), $urandom, 1'b0, rc);
		end
	endtask

	initial begin
		int target;
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = CMD_SEND;
		frame_more = 1'b0;
		frame_size = 16'd0;
		first_word = 32'd0;
		channel    = 3'd0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = 4'd0;
		pwdata     = 32'd0;
		quiet      = 1'b0;
		counting   = 1'b0;
		corr_now   = 1'b0;
		strict_now = 1'b1;
		n_rand     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: no id, strict
		put_item(CMD_ARRIVE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 3'd0);
		put_item(CMD_TERM, 1'b0, 16'd0, 32'd0, 1'b0, 3'd7);
		put_item(CMD_UNUSED, 1'b1, 16'hFFFF, 32'd0, 1'b0, 3'd5);
		put_item(CMD_SEND, 1'b1, 16'd0, 32'd0, 1'b0, 3'd7);
		put_item(CMD_SEND, 1'b0, 16'd0, 32'd0, 1'b0, 3'd3);
		put_item(CMD_SEND, 1'b0, 16'd0, 32'd0, 1'b0, 3'd2);
		put_item(CMD_ARRIVE, 1'b1, 16'd0, 32'd0, 1'b0, 3'd1);
		put_item(CMD_ARRIVE, 1'b1, 16'd5, 32'd0, 1'b0, 3'd7);
		put_item(CMD_ARRIVE, 1'b0, 16'd0, 32'd0, 1'b0, 3'd7);
		put_item(CMD_ARRIVE, 1'b1, 16'd0, 32'd0, 1'b0, 3'd7);
		put_item(CMD_ARRIVE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 3'd7);
		put_item(CMD_ARRIVE, 1'b0, 16'd3, 32'h1234_5678, 1'b0, 3'd7);

		// id frames, relaxed, counter wraps from the top seed
		set_config(1'b1, 1'b0, 32'hFFFF_FFFF);
		put_item(CMD_SEND, 1'b0, 16'd0, 32'd0, 1'b0, 3'd0);
		put_item(CMD_SEND, 1'b0, 16'd0, 32'd0, 1'b0, 3'd1);
		put_item(CMD_TERM, 1'b0, 16'd0, 32'd0, 1'b0, 3'd1);
		put_item(CMD_ARRIVE, 1'b1, 16'(ID_BYTES), 32'd0, 1'b1, 3'd6);
		put_item(CMD_ARRIVE, 1'b0, 16'd0, 32'd0, 1'b0, 3'd2);
		put_item(CMD_ARRIVE, 1'b1, 16'(ID_BYTES), 32'd1, 1'b1, 3'd3);
		put_item(CMD_ARRIVE, 1'b0, 16'd0, 32'd0, 1'b0, 3'd3);
		put_item(CMD_ARRIVE, 1'b0, 16'(ID_BYTES), 32'd0, 1'b1, 3'd4);
		put_item(CMD_ARRIVE, 1'b1, 16'(ID_BYTES), 32'd0, 1'b1, 3'd5);
		put_item(CMD_ARRIVE, 1'b1, 16'd0, 32'd0, 1'b0, 3'd5);
		put_item(CMD_ARRIVE, 1'b0, 16'd7, 32'd0, 1'b0, 3'd5);

		counting = 1'b1;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_config(1'b1, 1'b1, $urandom);
				1: set_config(1'b0, 1'b1, 32'd0);
				2: set_config(1'b1, 1'b0, 32'hFFFF_FFFE);
				default: set_config(1'b0, 1'b0, $urandom);
			endcase
			target = n_rand + 45;
			while (n_rand < target) begin
				if (p == 3 && n_rand >= target - 25)
					quiet = 1'b1;
				exchange();
			end
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/rref_pkg.sv
rtl/core/request_reply_envelope_filter.sv
tb/rref_checker.sv
tb/tb_request_reply_envelope_filter.sv
